// ===== sv/assert_macros.svh =====
// Assertion helpers, sampled on clock, off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== sv/v2r_pkg.sv =====
package v2r_pkg;

   localparam int WORK_W       = 32;
   localparam int NORM_STAGES  = 5;
   localparam int ROOT_BITS    = 32;
   localparam int RAD_W        = 2 * ROOT_BITS;
   localparam int REM_W        = ROOT_BITS + 2;
   localparam int QUO_BITS     = 31;
   localparam int FRAC_Q       = 30;
   localparam int OUT_W        = 16;
   localparam int IN_WIDTH_DEF = 16;
   localparam int OUT_FRAC_DEF = 14;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic zero;
      logic on_axis;
   } side_type;

endpackage

// ===== sv/v2r_norm_cell.sv =====
module v2r_norm_cell #(
   parameter int SHIFT = 1,
   parameter int LANES = 3
) (
   input  logic                                    clock,
   input  logic [v2r_pkg::WORK_W-1:0]              ref_i,
   input  logic [LANES-1:0][v2r_pkg::WORK_W-1:0]   lane_i,
   output logic [v2r_pkg::WORK_W-1:0]              ref_o,
   output logic [LANES-1:0][v2r_pkg::WORK_W-1:0]   lane_o
);
   import v2r_pkg::*;

   logic                            take;
   logic [WORK_W-1:0]               ref_in, ref_ff;
   logic [LANES-1:0][WORK_W-1:0]    lane_in, lane_ff;

   // shift when the reference is still below 2^(31-SHIFT)
   assign take = (ref_i[WORK_W-1 -: SHIFT+1] == '0);

   always_comb begin
      ref_in = take ? (ref_i << SHIFT) : ref_i;
      for (int l = 0; l < LANES; l++) begin
         lane_in[l] = take ? (lane_i[l] << SHIFT) : lane_i[l];
      end
   end

   always_ff @(posedge clock) begin
      ref_ff  <= ref_in;
      lane_ff <= lane_in;
   end

   assign ref_o  = ref_ff;
   assign lane_o = lane_ff;

endmodule

// ===== sv/v2r_sqrt_cell.sv =====
module v2r_sqrt_cell #(
   parameter int PASS_W = 96
) (
   input  logic                            clock,
   input  logic [v2r_pkg::RAD_W-1:0]       rad_i,
   input  logic [v2r_pkg::REM_W-1:0]       rem_i,
   input  logic [v2r_pkg::ROOT_BITS-1:0]   root_i,
   input  logic [PASS_W-1:0]               pass_i,
   output logic [v2r_pkg::RAD_W-1:0]       rad_o,
   output logic [v2r_pkg::REM_W-1:0]       rem_o,
   output logic [v2r_pkg::ROOT_BITS-1:0]   root_o,
   output logic [PASS_W-1:0]               pass_o
);
   import v2r_pkg::*;

   logic [REM_W+1:0]      part, trial;
   logic                  fits;
   logic [RAD_W-1:0]      rad_in, rad_ff;
   logic [REM_W-1:0]      rem_in, rem_ff;
   logic [ROOT_BITS-1:0]  root_in, root_ff;
   logic [PASS_W-1:0]     pass_ff;

   always_comb begin
      part    = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial   = {2'b00, root_i, 2'b01};
      fits    = (part >= trial);
      rem_in  = fits ? REM_W'(part - trial) : REM_W'(part);
      root_in = {root_i[ROOT_BITS-2:0], fits};
      rad_in  = rad_i << 2;
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      pass_ff <= pass_i;
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign pass_o = pass_ff;

endmodule

// ===== sv/v2r_div_cell.sv =====
module v2r_div_cell #(
   parameter int LANES = 3
) (
   input  logic                                     clock,
   input  logic [v2r_pkg::WORK_W-1:0]               den_i,
   input  logic [LANES-1:0][v2r_pkg::WORK_W-1:0]    rem_i,
   input  logic [LANES-1:0][v2r_pkg::QUO_BITS-1:0]  low_i,
   input  logic [LANES-1:0][v2r_pkg::QUO_BITS-1:0]  quo_i,
   output logic [v2r_pkg::WORK_W-1:0]               den_o,
   output logic [LANES-1:0][v2r_pkg::WORK_W-1:0]    rem_o,
   output logic [LANES-1:0][v2r_pkg::QUO_BITS-1:0]  low_o,
   output logic [LANES-1:0][v2r_pkg::QUO_BITS-1:0]  quo_o
);
   import v2r_pkg::*;

   logic [LANES-1:0][WORK_W:0]      part;
   logic [LANES-1:0]                fits;
   logic [WORK_W-1:0]               den_ff;
   logic [LANES-1:0][WORK_W-1:0]    rem_in, rem_ff;
   logic [LANES-1:0][QUO_BITS-1:0]  low_in, low_ff, quo_in, quo_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         part[l]   = {rem_i[l], low_i[l][QUO_BITS-1]};
         fits[l]   = (part[l] >= {1'b0, den_i});
         rem_in[l] = fits[l] ? WORK_W'(part[l] - {1'b0, den_i}) : WORK_W'(part[l]);
         low_in[l] = low_i[l] << 1;
         quo_in[l] = {quo_i[l][QUO_BITS-2:0], fits[l]};
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_i;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign quo_o = quo_ff;

endmodule

// ===== sv/vector_to_rotation_matrix.sv =====
// channel   ports                          transfer when
// request   start, busy, req_dir_*         start high and busy low
// result    rsp_valid, rsp_m_*, rsp_zero_* rsp_valid high, one cycle each
//
// One vector per cycle; busy is high only while reset is. A result's path runs through
// the 32-cell root chain and the 31-cell divider.
// Reset clears only the sideband (valid and flags) through the pipe and the output valid.
// The result side cannot stall; results are shown once and never held.
`include "assert_macros.svh"

module vector_to_rotation_matrix #(
   parameter int IN_WIDTH      = v2r_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = v2r_pkg::OUT_FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [IN_WIDTH-1:0]          req_dir_x,
   input  logic signed [IN_WIDTH-1:0]          req_dir_y,
   input  logic signed [IN_WIDTH-1:0]          req_dir_z,
   output logic                                rsp_valid,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c0_r0,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c0_r1,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c0_r2,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c1_r0,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c1_r1,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c1_r2,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c2_r0,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c2_r1,
   output logic signed [v2r_pkg::OUT_W-1:0]    rsp_m_c2_r2,
   output logic                                rsp_zero_vector
);
   import v2r_pkg::*;

   localparam int DIV_END  = 2 + NORM_STAGES + 2 + ROOT_BITS + 1 + QUO_BITS;
   localparam int TAP_M1   = DIV_END - 1;
   localparam int TAP_M3   = DIV_END + 1;
   localparam int TAP_OUT  = DIV_END + 2;
   localparam int SIDE_LEN = TAP_OUT + 1;
   localparam int NUM_W    = WORK_W + FRAC_Q;
   localparam int E_W      = WORK_W + 2;
   localparam int OUT_SH   = FRAC_Q - OUT_FRAC_BITS;

   localparam logic [RAD_W-1:0]      HALF_Q   = RAD_W'(1) << (FRAC_Q - 1);
   localparam logic [WORK_W-1:0]     QONE_W   = WORK_W'(1) << FRAC_Q;
   localparam logic signed [E_W-1:0] QONE_E   = E_W'(1) << FRAC_Q;
   localparam logic [E_W-1:0]        OUT_LIM  = E_W'(1) << OUT_FRAC_BITS;
   localparam logic [E_W-1:0]        OUT_HALF = (OUT_SH == 0) ? '0 : (E_W'(1) << (OUT_SH - 1));

   function automatic logic [OUT_W-1:0] to_out(input logic signed [E_W-1:0] v);
      logic [E_W-1:0]        mag;
      logic [E_W-1:0]        r;
      logic signed [E_W-1:0] s;
      mag = v[E_W-1] ? E_W'(-v) : E_W'(v);
      r   = (mag + OUT_HALF) >> OUT_SH;
      if (r > OUT_LIM) r = OUT_LIM;
      s   = v[E_W-1] ? -$signed(r) : $signed(r);
      return s[OUT_W-1:0];
   endfunction

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // input stage: magnitudes and sideband
   logic signed [WORK_W:0] ext_x, ext_y, ext_z;
   logic [WORK_W-1:0]      ax_in, ay_in, az_in, ax_ff, ay_ff, az_ff;
   side_type               sb_in;
   side_type               sb_ff [SIDE_LEN];

   always_comb begin
      ext_x = (WORK_W+1)'(req_dir_x);
      ext_y = (WORK_W+1)'(req_dir_y);
      ext_z = (WORK_W+1)'(req_dir_z);
      ax_in = ext_x[WORK_W] ? WORK_W'(-ext_x) : WORK_W'(ext_x);
      ay_in = ext_y[WORK_W] ? WORK_W'(-ext_y) : WORK_W'(ext_y);
      az_in = ext_z[WORK_W] ? WORK_W'(-ext_z) : WORK_W'(ext_z);
      sb_in.valid   = accept;
      sb_in.neg_x   = ext_x[WORK_W];
      sb_in.neg_y   = ext_y[WORK_W];
      sb_in.neg_z   = ext_z[WORK_W];
      sb_in.zero    = (req_dir_x == 0) && (req_dir_y == 0) && (req_dir_z == 0);
      sb_in.on_axis = (req_dir_x == 0) && (req_dir_z == 0);
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      az_ff <= az_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_LEN; i++) sb_ff[i] <= '0;
      end else begin
         sb_ff[0] <= sb_in;
         for (int i = 1; i < SIDE_LEN; i++) sb_ff[i] <= sb_ff[i-1];
      end
   end

   // max stage
   logic [WORK_W-1:0]          mxz_in, mx3_in, mx3_ff, mx2_ff;
   logic [2:0][WORK_W-1:0]     l3_ff;
   logic [1:0][WORK_W-1:0]     l2_ff;

   always_comb begin
      mxz_in = (az_ff > ax_ff) ? az_ff : ax_ff;
      mx3_in = (ay_ff > mxz_in) ? ay_ff : mxz_in;
   end

   always_ff @(posedge clock) begin
      mx3_ff <= mx3_in;
      mx2_ff <= mxz_in;
      l3_ff  <= {az_ff, ay_ff, ax_ff};
      l2_ff  <= {az_ff, ax_ff};
   end

   // normalizer chains
   logic [WORK_W-1:0]       n3_ref  [NORM_STAGES+1];
   logic [2:0][WORK_W-1:0]  n3_lane [NORM_STAGES+1];
   logic [WORK_W-1:0]       n2_ref  [NORM_STAGES+1];
   logic [1:0][WORK_W-1:0]  n2_lane [NORM_STAGES+1];

   assign n3_ref[0]  = mx3_ff;
   assign n3_lane[0] = l3_ff;
   assign n2_ref[0]  = mx2_ff;
   assign n2_lane[0] = l2_ff;

   for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
      v2r_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - g)), .LANES(3)) u_n3 (
         .clock (clock),
         .ref_i (n3_ref[g]),
         .lane_i(n3_lane[g]),
         .ref_o (n3_ref[g+1]),
         .lane_o(n3_lane[g+1])
      );
      v2r_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - g)), .LANES(2)) u_n2 (
         .clock (clock),
         .ref_i (n2_ref[g]),
         .lane_i(n2_lane[g]),
         .ref_o (n2_ref[g+1]),
         .lane_o(n2_lane[g+1])
      );
   end

   // squares, then sums
   logic [2:0][RAD_W-1:0]   sq3_in, sq3_ff;
   logic [1:0][RAD_W-1:0]   sq2_in, sq2_ff;
   logic [2:0][WORK_W-1:0]  p3a_ff, p3b_ff;
   logic [1:0][WORK_W-1:0]  p2a_ff, p2b_ff;
   logic [RAD_W-1:0]        q3_ff, q2_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sq3_in[l] = RAD_W'(n3_lane[NORM_STAGES][l]) * RAD_W'(n3_lane[NORM_STAGES][l]);
      end
      for (int l = 0; l < 2; l++) begin
         sq2_in[l] = RAD_W'(n2_lane[NORM_STAGES][l]) * RAD_W'(n2_lane[NORM_STAGES][l]);
      end
   end

   always_ff @(posedge clock) begin
      sq3_ff <= sq3_in;
      sq2_ff <= sq2_in;
      p3a_ff <= n3_lane[NORM_STAGES];
      p2a_ff <= n2_lane[NORM_STAGES];
      q3_ff  <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
      q2_ff  <= sq2_ff[0] + sq2_ff[1];
      p3b_ff <= p3a_ff;
      p2b_ff <= p2a_ff;
   end

   // root chains
   logic [RAD_W-1:0]       r3_rad  [ROOT_BITS+1];
   logic [REM_W-1:0]       r3_rem  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]   r3_root [ROOT_BITS+1];
   logic [3*WORK_W-1:0]    r3_pass [ROOT_BITS+1];
   logic [RAD_W-1:0]       r2_rad  [ROOT_BITS+1];
   logic [REM_W-1:0]       r2_rem  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]   r2_root [ROOT_BITS+1];
   logic [2*WORK_W-1:0]    r2_pass [ROOT_BITS+1];

   assign r3_rad[0]  = q3_ff;
   assign r3_rem[0]  = '0;
   assign r3_root[0] = '0;
   assign r3_pass[0] = p3b_ff;
   assign r2_rad[0]  = q2_ff;
   assign r2_rem[0]  = '0;
   assign r2_root[0] = '0;
   assign r2_pass[0] = p2b_ff;

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
      v2r_sqrt_cell #(.PASS_W(3*WORK_W)) u_r3 (
         .clock (clock),
         .rad_i (r3_rad[g]),
         .rem_i (r3_rem[g]),
         .root_i(r3_root[g]),
         .pass_i(r3_pass[g]),
         .rad_o (r3_rad[g+1]),
         .rem_o (r3_rem[g+1]),
         .root_o(r3_root[g+1]),
         .pass_o(r3_pass[g+1])
      );
      v2r_sqrt_cell #(.PASS_W(2*WORK_W)) u_r2 (
         .clock (clock),
         .rad_i (r2_rad[g]),
         .rem_i (r2_rem[g]),
         .root_i(r2_root[g]),
         .pass_i(r2_pass[g]),
         .rad_o (r2_rad[g+1]),
         .rem_o (r2_rem[g+1]),
         .root_o(r2_root[g+1]),
         .pass_o(r2_pass[g+1])
      );
   end

   // divider setup: numerator = mag * 2^30 + floor(den / 2)
   logic [2:0][WORK_W-1:0]    m3_lane;
   logic [1:0][WORK_W-1:0]    m2_lane;
   logic [2:0][NUM_W-1:0]     num3;
   logic [1:0][NUM_W-1:0]     num2;
   logic [2:0][WORK_W-1:0]    d3r_ff;
   logic [2:0][QUO_BITS-1:0]  d3l_ff;
   logic [1:0][WORK_W-1:0]    d2r_ff;
   logic [1:0][QUO_BITS-1:0]  d2l_ff;
   logic [WORK_W-1:0]         den3_ff, den2_ff;

   always_comb begin
      m3_lane = r3_pass[ROOT_BITS];
      m2_lane = r2_pass[ROOT_BITS];
      for (int l = 0; l < 3; l++) begin
         num3[l] = NUM_W'({m3_lane[l], {FRAC_Q{1'b0}}}) + NUM_W'(r3_root[ROOT_BITS] >> 1);
      end
      for (int l = 0; l < 2; l++) begin
         num2[l] = NUM_W'({m2_lane[l], {FRAC_Q{1'b0}}}) + NUM_W'(r2_root[ROOT_BITS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      den3_ff <= WORK_W'(r3_root[ROOT_BITS]);
      den2_ff <= WORK_W'(r2_root[ROOT_BITS]);
      for (int l = 0; l < 3; l++) begin
         d3r_ff[l] <= WORK_W'(num3[l][NUM_W-1:QUO_BITS]);
         d3l_ff[l] <= num3[l][QUO_BITS-1:0];
      end
      for (int l = 0; l < 2; l++) begin
         d2r_ff[l] <= WORK_W'(num2[l][NUM_W-1:QUO_BITS]);
         d2l_ff[l] <= num2[l][QUO_BITS-1:0];
      end
   end

   // divider chains
   logic [WORK_W-1:0]         v3_den [QUO_BITS+1];
   logic [2:0][WORK_W-1:0]    v3_rem [QUO_BITS+1];
   logic [2:0][QUO_BITS-1:0]  v3_low [QUO_BITS+1];
   logic [2:0][QUO_BITS-1:0]  v3_quo [QUO_BITS+1];
   logic [WORK_W-1:0]         v2_den [QUO_BITS+1];
   logic [1:0][WORK_W-1:0]    v2_rem [QUO_BITS+1];
   logic [1:0][QUO_BITS-1:0]  v2_low [QUO_BITS+1];
   logic [1:0][QUO_BITS-1:0]  v2_quo [QUO_BITS+1];

   assign v3_den[0] = den3_ff;
   assign v3_rem[0] = d3r_ff;
   assign v3_low[0] = d3l_ff;
   assign v3_quo[0] = '0;
   assign v2_den[0] = den2_ff;
   assign v2_rem[0] = d2r_ff;
   assign v2_low[0] = d2l_ff;
   assign v2_quo[0] = '0;

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      v2r_div_cell #(.LANES(3)) u_d3 (
         .clock(clock),
         .den_i(v3_den[g]),
         .rem_i(v3_rem[g]),
         .low_i(v3_low[g]),
         .quo_i(v3_quo[g]),
         .den_o(v3_den[g+1]),
         .rem_o(v3_rem[g+1]),
         .low_o(v3_low[g+1]),
         .quo_o(v3_quo[g+1])
      );
      v2r_div_cell #(.LANES(2)) u_d2 (
         .clock(clock),
         .den_i(v2_den[g]),
         .rem_i(v2_rem[g]),
         .low_i(v2_low[g]),
         .quo_i(v2_quo[g]),
         .den_o(v2_den[g+1]),
         .rem_o(v2_rem[g+1]),
         .low_o(v2_low[g+1]),
         .quo_o(v2_quo[g+1])
      );
   end

   // outer products of the axis, then scaling by 1 - c
   logic [QUO_BITS-1:0]    c_m, nx_m, nz_m, au_m, aw_m;
   logic [RAD_W-1:0]       puu, pww, puw;
   logic [WORK_W-1:0]      uu1_in, ww1_in, uw1_in, k1_in;
   logic [WORK_W-1:0]      uu1_ff, ww1_ff, uw1_ff, k1_ff;
   logic signed [E_W-1:0]  c1_in, nx1_in, nz1_in, c1_ff, nx1_ff, nz1_ff;
   logic                   uwn1_in, uwn1_ff;
   side_type               s1;

   always_comb begin
      s1      = sb_ff[TAP_M1];
      nx_m    = v3_quo[QUO_BITS][0];
      c_m     = v3_quo[QUO_BITS][1];
      nz_m    = v3_quo[QUO_BITS][2];
      aw_m    = v2_quo[QUO_BITS][0];
      au_m    = v2_quo[QUO_BITS][1];
      puu     = RAD_W'(au_m) * RAD_W'(au_m);
      pww     = RAD_W'(aw_m) * RAD_W'(aw_m);
      puw     = RAD_W'(au_m) * RAD_W'(aw_m);
      uu1_in  = WORK_W'((puu + HALF_Q) >> FRAC_Q);
      ww1_in  = WORK_W'((pww + HALF_Q) >> FRAC_Q);
      uw1_in  = WORK_W'((puw + HALF_Q) >> FRAC_Q);
      uwn1_in = s1.neg_z ^ !s1.neg_x;
      k1_in   = s1.neg_y ? QONE_W + WORK_W'(c_m) : QONE_W - WORK_W'(c_m);
      c1_in   = s1.neg_y ? -$signed(E_W'(c_m)) : $signed(E_W'(c_m));
      nx1_in  = s1.neg_x ? -$signed(E_W'(nx_m)) : $signed(E_W'(nx_m));
      nz1_in  = s1.neg_z ? -$signed(E_W'(nz_m)) : $signed(E_W'(nz_m));
   end

   always_ff @(posedge clock) begin
      uu1_ff  <= uu1_in;
      ww1_ff  <= ww1_in;
      uw1_ff  <= uw1_in;
      k1_ff   <= k1_in;
      uwn1_ff <= uwn1_in;
      c1_ff   <= c1_in;
      nx1_ff  <= nx1_in;
      nz1_ff  <= nz1_in;
   end

   logic [RAD_W-1:0]       kuu, kww, kuw;
   logic [WORK_W:0]        uu2_in, ww2_in, uw2_in, uu2_ff, ww2_ff, uw2_ff;
   logic signed [E_W-1:0]  c2_ff, nx2_ff, nz2_ff;
   logic                   uwn2_ff;

   always_comb begin
      kuu    = RAD_W'(uu1_ff) * RAD_W'(k1_ff);
      kww    = RAD_W'(ww1_ff) * RAD_W'(k1_ff);
      kuw    = RAD_W'(uw1_ff) * RAD_W'(k1_ff);
      uu2_in = (WORK_W+1)'((kuu + HALF_Q) >> FRAC_Q);
      ww2_in = (WORK_W+1)'((kww + HALF_Q) >> FRAC_Q);
      uw2_in = (WORK_W+1)'((kuw + HALF_Q) >> FRAC_Q);
   end

   always_ff @(posedge clock) begin
      uu2_ff  <= uu2_in;
      ww2_ff  <= ww2_in;
      uw2_ff  <= uw2_in;
      uwn2_ff <= uwn1_ff;
      c2_ff   <= c1_ff;
      nx2_ff  <= nx1_ff;
      nz2_ff  <= nz1_ff;
   end

   // entries in Q30, column-major
   logic signed [E_W-1:0]  e_in [9];
   logic signed [E_W-1:0]  e_ff [9];
   logic signed [E_W-1:0]  uw_s;
   side_type               s3;

   always_comb begin
      s3   = sb_ff[TAP_M3];
      uw_s = uwn2_ff ? -$signed(E_W'(uw2_ff)) : $signed(E_W'(uw2_ff));
      for (int i = 0; i < 9; i++) e_in[i] = '0;
      if (s3.zero) begin
         e_in[0] = QONE_E;
         e_in[4] = QONE_E;
         e_in[8] = QONE_E;
      end else if (s3.on_axis) begin
         e_in[0] = c2_ff;
         e_in[4] = c2_ff;
         e_in[8] = c2_ff;
      end else begin
         e_in[0] = c2_ff + $signed(E_W'(uu2_ff));
         e_in[1] = -nx2_ff;
         e_in[2] = uw_s;
         e_in[3] = nx2_ff;
         e_in[4] = c2_ff;
         e_in[5] = nz2_ff;
         e_in[6] = uw_s;
         e_in[7] = -nz2_ff;
         e_in[8] = c2_ff + $signed(E_W'(ww2_ff));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) e_ff[i] <= e_in[i];
   end

   // output register
   logic [OUT_W-1:0] o_ff [9];
   logic             zero_ff;
   logic             valid_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) o_ff[i] <= to_out(e_ff[i]);
      zero_ff <= sb_ff[TAP_OUT].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sb_ff[TAP_OUT].valid;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_zero_vector = zero_ff;
   assign rsp_m_c0_r0     = o_ff[0];
   assign rsp_m_c0_r1     = o_ff[1];
   assign rsp_m_c0_r2     = o_ff[2];
   assign rsp_m_c1_r0     = o_ff[3];
   assign rsp_m_c1_r1     = o_ff[4];
   assign rsp_m_c1_r2     = o_ff[5];
   assign rsp_m_c2_r0     = o_ff[6];
   assign rsp_m_c2_r1     = o_ff[7];
   assign rsp_m_c2_r2     = o_ff[8];

   `ASSERT_IMPLY(a_latency, rsp_valid, $past(start && !busy, TAP_OUT + 2), "result without transfer")
   `ASSERT_IMPLY(a_norm3, sb_ff[NORM_STAGES+1].valid && !sb_ff[NORM_STAGES+1].zero, n3_ref[NORM_STAGES][WORK_W-1 -: 2] != 2'b00, "vector not normalized")
   `ASSERT_IMPLY(a_norm2, sb_ff[NORM_STAGES+1].valid && !sb_ff[NORM_STAGES+1].on_axis, n2_ref[NORM_STAGES][WORK_W-1 -: 2] != 2'b00, "axis pair not normalized")
   `ASSERT_IMPLY(a_antisym, rsp_valid, rsp_m_c1_r0 == -rsp_m_c0_r1, "x terms not antisymmetric")

endmodule
